/* rtl/socket_endpoint_demux_table_unit_macros.svh */
// Assertion helpers for the endpoint table checker.
`ifndef SOCKET_ENDPOINT_DEMUX_TABLE_UNIT_MACROS_SVH
`define SOCKET_ENDPOINT_DEMUX_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SEDT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("endpoint table check failed");

// Next-cycle implication, off while reset is high.
`define SEDT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("endpoint table check failed");

`endif

/* rtl/sedt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sedt_pkg;

  localparam int TABLE_DEPTH    = 64;
  localparam int DEVICE_ID_BITS = 4;
  localparam int IDX_BITS       = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS       = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [15:0] EPH_FIRST_RESET = 16'd49152;
  localparam logic [15:0] EPH_LAST_RESET  = 16'd65535;

  localparam logic [CFG_IDX_BITS-1:0] CFG_EPH_FIRST = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EPH_LAST  = 1'd1;

  localparam logic [2:0] REQ_LOOKUP     = 3'd0;
  localparam logic [2:0] REQ_BIND_LOCAL = 3'd1;
  localparam logic [2:0] REQ_BIND_CONN  = 3'd2;
  localparam logic [2:0] REQ_BIND_EPH   = 3'd3;
  localparam logic [2:0] REQ_RELEASE    = 3'd4;
  localparam logic [2:0] REQ_SET_ATTR   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NO_PORT   = 3'd4;
  localparam logic [2:0] ST_AMBIGUOUS = 3'd5;

  typedef struct packed {
    logic [2:0]                req_type;
    logic [31:0]               local_addr;
    logic [15:0]               local_port;
    logic [31:0]               peer_addr;
    logic [15:0]               peer_port;
    logic [DEVICE_ID_BITS-1:0] device_id;
    logic [31:0]               iface_addr;
    logic [31:0]               iface_mask;
    logic [5:0]                slot;
    logic                      rx_enable;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  hit_slot;
    logic [15:0] assigned_port;
    logic [2:0]  match_class;
  } rsp_t;

  typedef struct packed {
    logic                      rx_enabled;
    logic [DEVICE_ID_BITS-1:0] device;
    logic [31:0]               local_addr;
    logic [15:0]               local_port;
    logic [31:0]               peer_addr;
    logic [15:0]               peer_port;
  } entry_t;

  // per-entry scan flags; cls bit c-1 is class c
  typedef struct packed {
    logic [3:0] cls;
    logic       dup;
    logic       port_used;
    logic       free;
  } match_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_SLOT,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

/* rtl/sedt_entry_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module sedt_entry_mem (
  input  wire                          clk,
  input  wire  [sedt_pkg::IDX_BITS-1:0] raddr,
  output sedt_pkg::entry_t             rdata,
  input  wire                          we,
  input  wire  [sedt_pkg::IDX_BITS-1:0] waddr,
  input  sedt_pkg::entry_t             wdata
);
  import sedt_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/sedt_match.sv */
`timescale 1ns / 1ps
`default_nettype none
module sedt_match (
  input  sedt_pkg::entry_t ent,
  input  wire              ent_valid,
  input  sedt_pkg::req_t   req,
  input  wire  [15:0]      cand_port,
  output sedt_pkg::match_t m
);
  import sedt_pkg::*;

  logic [31:0] net;
  logic        base, ex, wild, pex, pw, aex, aw, ok, dev_ok, lp_eq;

  always_comb begin
    net    = req.iface_addr & req.iface_mask;
    lp_eq  = ent.local_port == req.local_port;
    dev_ok = (ent.device == '0) || (ent.device == req.device_id);
    base   = ent_valid && lp_eq && ent.rx_enabled && dev_ok;
    ex     = ent.local_addr == req.local_addr;
    wild   = !ex && ((ent.local_addr == '0) ||
             ((ent.local_addr == net) && ((req.local_addr & req.iface_mask) == net)));
    pex    = ent.peer_port == req.peer_port;
    pw     = ent.peer_port == '0;
    aex    = ent.peer_addr == req.peer_addr;
    aw     = ent.peer_addr == '0;
    ok     = base && (ex || wild) && (pex || pw) && (aex || aw);

    m.cls[3] = ok && ex && aex && pex;
    m.cls[2] = ok && wild && aex && pex;
    m.cls[1] = ok && ex && aw && pw;
    m.cls[0] = ok && wild && aw && pw;
    // connected bind also compares the peer side
    m.dup = ent_valid && ex && lp_eq && dev_ok &&
            ((req.req_type != REQ_BIND_CONN) || (aex && pex));
    m.port_used = ent_valid && (ent.local_port == cand_port);
    m.free      = !ent_valid;
  end

endmodule
`default_nettype wire

/* rtl/socket_endpoint_demux_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// IPv4 socket endpoint table: one request word in, one response word out.
// Entries live in a single-port-read synchronous RAM; valid bits are flops
// cleared by reset, so the table is empty right after reset with no clearing
// pass. Lookup, bind local and bind connected walk every entry once: the
// request is accepted, each entry is read in turn, the last read's data
// arrives, an evaluate step follows and then the response. Release and
// set attributes read one entry. Unknown request codes answer with no read.
// Ephemeral bind walks the table once per candidate port, for k candidates
// tried, k at most ephemeral_last - ephemeral_first + 1. A stalled output
// holds the block in its response state. One request is in work at a time;
// a finished response sits in the output register while the next request
// is accepted. The user must write the ephemeral range registers through
// cfg_we / cfg_index / cfg_data only while the block is idle; the block
// does not enforce this.
module socket_endpoint_demux_table_unit (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                req_valid,
  output logic                               req_stall,
  input  sedt_pkg::req_t                     req_data,
  output logic                               rsp_valid,
  input  wire                                rsp_stall,
  output sedt_pkg::rsp_t                     rsp_data,
  input  wire                                cfg_we,
  input  wire  [sedt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [sedt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import sedt_pkg::*;

  state_t state, state_next;

  // configuration and allocator state
  logic [15:0] eph_first, eph_last, last_eph;

  // entry valid bits
  logic [TABLE_DEPTH-1:0] valid;

  // request in work and scan accumulators
  req_t                req_q;
  logic [CNT_BITS-1:0] k;
  logic [1:0]          cnt [4];   // saturates at 2: one hit or ambiguous
  logic [IDX_BITS-1:0] hit [4];
  logic                dup, used, free_found;
  logic [IDX_BITS-1:0] free_idx;
  logic [15:0]         cand;
  logic [16:0]         rem;       // candidates left, up to 65536
  rsp_t                res;

  // RAM side
  logic [IDX_BITS-1:0] mem_raddr, mem_waddr, pidx, slot_idx;
  entry_t              mem_rdata, mem_wdata;
  logic                mem_we;
  match_t              m;

  // control from the output block
  logic   accept, scan_clear, eph_ok, eph_retry, res_load, out_load;
  logic   vset, vclr, slot_ok;
  rsp_t   res_next;

  function automatic logic [15:0] next_port(input logic [15:0] p,
                                            input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [15:0] q;
    q = p + 16'd1;
    if (q < lo || q > hi) begin
      q = lo;
    end
    return q;
  endfunction

  assign accept    = req_valid && !req_stall;
  assign req_stall = state != S_IDLE;
  assign pidx      = IDX_BITS'(k - CNT_BITS'(1));
  assign slot_idx  = IDX_BITS'(req_q.slot);
  assign slot_ok   = (32'(req_q.slot) < TABLE_DEPTH) && valid[slot_idx];
  assign scan_clear = (accept && (req_data.req_type inside {REQ_LOOKUP, REQ_BIND_LOCAL,
                       REQ_BIND_CONN, REQ_BIND_EPH})) || eph_retry;

  sedt_entry_mem u_mem (
    .clk   (clk),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  sedt_match u_match (
    .ent       (mem_rdata),
    .ent_valid (valid[pidx]),
    .req       (req_q),
    .cand_port (cand),
    .m         (m)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_data.req_type)
            REQ_LOOKUP, REQ_BIND_LOCAL, REQ_BIND_CONN, REQ_BIND_EPH: state_next = S_SCAN;
            REQ_RELEASE, REQ_SET_ATTR: state_next = S_SLOT;
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_SCAN: begin
        if (k == CNT_BITS'(TABLE_DEPTH)) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: state_next = eph_retry ? S_SCAN : S_EMIT;
      S_SLOT: state_next = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs: RAM control, valid updates, response build
  always_comb begin
    mem_raddr = (state == S_IDLE) ? IDX_BITS'(req_data.slot) : k[IDX_BITS-1:0];
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = '{rx_enabled: 1'b1, device: '0, local_addr: req_q.local_addr,
                  local_port: req_q.local_port, peer_addr: '0, peer_port: '0};
    vset      = 1'b0;
    vclr      = 1'b0;
    eph_ok    = 1'b0;
    eph_retry = 1'b0;
    res_load  = 1'b0;
    out_load  = 1'b0;
    res_next  = '{status: ST_NOT_FOUND, hit_slot: '0, assigned_port: '0, match_class: '0};
    case (state)
      S_IDLE: begin
        // unknown codes answer at once
        res_load = accept;
      end
      S_EVAL: begin
        res_load = 1'b1;
        case (req_q.req_type)
          REQ_LOOKUP: begin
            for (int c = 0; c < 4; c++) begin
              if (cnt[c] != 2'd0) begin
                res_next.status        = (cnt[c] == 2'd2) ? ST_AMBIGUOUS : ST_OK;
                res_next.hit_slot      = 6'(hit[c]);
                res_next.assigned_port = req_q.local_port;
                res_next.match_class   = 3'(c + 1);
              end
            end
          end
          REQ_BIND_LOCAL, REQ_BIND_CONN: begin
            if (dup) begin
              res_next.status = ST_DUPLICATE;
            end else if (!free_found) begin
              res_next.status = ST_FULL;
            end else begin
              mem_we = 1'b1;
              vset   = 1'b1;
              if (req_q.req_type == REQ_BIND_CONN) begin
                mem_wdata.peer_addr = req_q.peer_addr;
                mem_wdata.peer_port = req_q.peer_port;
              end
              res_next = '{status: ST_OK, hit_slot: 6'(free_idx),
                           assigned_port: req_q.local_port, match_class: '0};
            end
          end
          REQ_BIND_EPH: begin
            if (!free_found) begin
              res_next.status = ST_FULL;
            end else if (rem == 17'd0) begin
              res_next.status = ST_NO_PORT;
            end else if (cand != 16'd0 && !used) begin
              mem_we               = 1'b1;
              vset                 = 1'b1;
              eph_ok               = 1'b1;
              mem_wdata.local_port = cand;
              res_next = '{status: ST_OK, hit_slot: 6'(free_idx),
                           assigned_port: cand, match_class: '0};
            end else if (rem == 17'd1) begin
              res_next.status = ST_NO_PORT;
            end else begin
              eph_retry = 1'b1;
              res_load  = 1'b0;
            end
          end
          default: ;
        endcase
      end
      S_SLOT: begin
        res_load = 1'b1;
        if (slot_ok) begin
          if (req_q.req_type == REQ_RELEASE) begin
            vclr = 1'b1;
          end else begin
            mem_we               = 1'b1;
            mem_waddr            = slot_idx;
            mem_wdata            = mem_rdata;
            mem_wdata.rx_enabled = req_q.rx_enable;
            mem_wdata.device     = req_q.device_id;
          end
          res_next = '{status: ST_OK, hit_slot: req_q.slot,
                       assigned_port: mem_rdata.local_port, match_class: '0};
        end
      end
      S_EMIT: out_load = !rsp_valid || !rsp_stall;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      valid     <= '0;
      eph_first <= EPH_FIRST_RESET;
      eph_last  <= EPH_LAST_RESET;
      last_eph  <= EPH_FIRST_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_EPH_FIRST: eph_first <= cfg_data;
          CFG_EPH_LAST:  eph_last  <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (vset) begin
        valid[free_idx] <= 1'b1;
      end
      if (vclr) begin
        valid[slot_idx] <= 1'b0;
      end
      if (eph_ok) begin
        last_eph <= cand;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_data;
      cand  <= next_port(last_eph, eph_first, eph_last);
      rem   <= (eph_first <= eph_last) ?
               ({1'b0, eph_last} - {1'b0, eph_first} + 17'd1) : 17'd0;
    end
    if (eph_retry) begin
      cand <= next_port(cand, eph_first, eph_last);
      rem  <= rem - 17'd1;
    end
    if (scan_clear) begin
      k          <= '0;
      dup        <= 1'b0;
      used       <= 1'b0;
      free_found <= 1'b0;
      for (int c = 0; c < 4; c++) begin
        cnt[c] <= 2'd0;
      end
    end else if (state == S_SCAN) begin
      k <= k + CNT_BITS'(1);
      // data for entry k-1 is on the RAM output now
      if (k != '0) begin
        for (int c = 0; c < 4; c++) begin
          if (m.cls[c]) begin
            hit[c] <= pidx;
            if (cnt[c] != 2'd2) begin
              cnt[c] <= cnt[c] + 2'd1;
            end
          end
        end
        if (m.dup) begin
          dup <= 1'b1;
        end
        if (m.port_used) begin
          used <= 1'b1;
        end
        if (m.free && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= pidx;
        end
      end
    end
    if (res_load) begin
      res <= res_next;
    end
    if (out_load) begin
      rsp_data <= res;
    end
  end

endmodule
`default_nettype wire

/* rtl/sedt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "socket_endpoint_demux_table_unit_macros.svh"
module sedt_checker (
  input wire            clk,
  input wire            rst,
  input wire            req_valid,
  input wire            req_stall,
  input wire            rsp_valid,
  input wire            rsp_stall,
  input sedt_pkg::rsp_t rsp_data
);
  import sedt_pkg::*;

  // a held response word stays offered
  `SEDT_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid)
  // one request in work at a time
  `SEDT_ASSERT_NXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  // ambiguous only comes from a lookup with a class
  `SEDT_ASSERT_IMP(a_amb_class, clk, rst,
    rsp_valid && rsp_data.status == ST_AMBIGUOUS, rsp_data.match_class != 3'd0)
  // a miss carries no entry
  `SEDT_ASSERT_IMP(a_miss_clean, clk, rst,
    rsp_valid && rsp_data.status == ST_NOT_FOUND,
    rsp_data.hit_slot == 6'd0 && rsp_data.assigned_port == 16'd0 &&
    rsp_data.match_class == 3'd0)
  // refused binds carry no entry
  `SEDT_ASSERT_IMP(a_refuse_clean, clk, rst,
    rsp_valid && (rsp_data.status == ST_DUPLICATE || rsp_data.status == ST_FULL ||
    rsp_data.status == ST_NO_PORT),
    rsp_data.hit_slot == 6'd0 && rsp_data.assigned_port == 16'd0)

endmodule

bind socket_endpoint_demux_table_unit sedt_checker u_sedt_checker (.*);
`default_nettype wire
